// ===== design/lsdm_pkg.sv =====
// ----------------------------------------------------------------------------
// lsdm_pkg
// Shared types and constants of the looping sample drone mixer: field widths,
// command codes, the decoded operation that travels through the queue, and
// the configuration register map.
// ----------------------------------------------------------------------------
package lsdm_pkg;

    // field widths of the channels
    localparam int CMD_W      = 3;
    localparam int VOICE_W    = 2;
    localparam int ADDR_W     = 12;
    localparam int SAMPLE_W   = 16;
    localparam int LENGTH_W   = 13;
    localparam int RATE_W     = 20;
    localparam int OUT_W      = 20;

    // configuration registers
    localparam int GAIN_W     = 16;
    localparam int PITCH_W    = 18;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_GAIN  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_FACTOR = 1'd1;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd16384;
    localparam logic [PITCH_W-1:0] PITCH_RESET = 18'd65536;

    // fixed point: phase and pitch carry sixteen fraction bits
    localparam int FRAC_W = 16;

    // output saturation bounds
    localparam int OUT_MAX = 524287;
    localparam int OUT_MIN = -524288;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD      = 3'd0,
        CMD_SET_VOICE = 3'd1,
        CMD_TOGGLE    = 3'd2,
        CMD_ALL_OFF   = 3'd3,
        CMD_TICK      = 3'd4
    } cmd_t;

    // decoded, range-checked operation
    typedef struct packed {
        cmd_t                        kind;
        logic [VOICE_W-1:0]          voice;
        logic [ADDR_W-1:0]           address;
        logic signed [SAMPLE_W-1:0]  sample;
        logic [LENGTH_W-1:0]         length;
        logic [RATE_W-1:0]           rate;
    } op_t;

    // queue fill status
    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

// ===== design/lsdm_front.sv =====
// ----------------------------------------------------------------------------
// lsdm_front
// Input side: takes items, drops those that do nothing (unknown codes,
// voice or address out of range), clamps the loop length and pushes the
// decoded operation into the command queue.
// ----------------------------------------------------------------------------
module lsdm_front #(
    parameter int VOICE_COUNT = 4,
    parameter int LOOP_DEPTH  = 4096
) (
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [lsdm_pkg::CMD_W-1:0]            s_command,
    input  logic [lsdm_pkg::VOICE_W-1:0]          s_voice,
    input  logic [lsdm_pkg::ADDR_W-1:0]           s_address,
    input  logic signed [lsdm_pkg::SAMPLE_W-1:0]  s_sample_value,
    input  logic [lsdm_pkg::LENGTH_W-1:0]         s_length,
    input  logic [lsdm_pkg::RATE_W-1:0]           s_rate,
    input  lsdm_pkg::queue_status_t               q_status,
    output logic                                  q_push,
    output lsdm_pkg::op_t                         q_op
);

    logic voice_ok;
    logic addr_ok;
    logic keep;
    logic [lsdm_pkg::LENGTH_W-1:0] length_clamped;

    // range checks
    assign voice_ok = (int'(s_voice) < VOICE_COUNT);
    assign addr_ok  = (int'(s_address) < LOOP_DEPTH);

    // loop length saturates at the loop depth
    assign length_clamped = (int'(s_length) > LOOP_DEPTH) ?
                            lsdm_pkg::LENGTH_W'(LOOP_DEPTH) : s_length;

    // classify the item
    always_comb begin
        keep = 1'b0;
        case (s_command)
            lsdm_pkg::CMD_LOAD:      keep = voice_ok && addr_ok;
            lsdm_pkg::CMD_SET_VOICE: keep = voice_ok;
            lsdm_pkg::CMD_TOGGLE:    keep = voice_ok;
            lsdm_pkg::CMD_ALL_OFF:   keep = 1'b1;
            lsdm_pkg::CMD_TICK:      keep = 1'b1;
            default:                 keep = 1'b0;
        endcase
    end

    // decoded operation
    always_comb begin
        q_op.kind    = lsdm_pkg::cmd_t'(s_command);
        q_op.voice   = s_voice;
        q_op.address = s_address;
        q_op.sample  = s_sample_value;
        q_op.length  = length_clamped;
        q_op.rate    = s_rate;
    end

    // items that do nothing are taken and dropped
    assign s_ready = !q_status.full;
    assign q_push  = s_valid && s_ready && keep;

endmodule

// ===== design/lsdm_queue.sv =====
// ----------------------------------------------------------------------------
// lsdm_queue
// Short first-in first-out queue of decoded operations between the front
// and the back, so that either side can stall without holding the other.
// ----------------------------------------------------------------------------
module lsdm_queue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  lsdm_pkg::op_t            push_op,
    input  logic                     pop,
    output lsdm_pkg::op_t            pop_op,
    output lsdm_pkg::queue_status_t  status
);

    lsdm_pkg::op_t                  slot_reg [lsdm_pkg::QUEUE_DEPTH];
    logic [lsdm_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [lsdm_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [lsdm_pkg::QCNT_W-1:0]    count_reg;
    logic [lsdm_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [lsdm_pkg::QPTR_W-1:0]    rd_ptr_next;

    // pointer wrap
    assign wr_ptr_next = (wr_ptr_reg == lsdm_pkg::QPTR_W'(lsdm_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : wr_ptr_reg + lsdm_pkg::QPTR_W'(1);
    assign rd_ptr_next = (rd_ptr_reg == lsdm_pkg::QPTR_W'(lsdm_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : rd_ptr_reg + lsdm_pkg::QPTR_W'(1);

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop) begin
                count_reg <= count_reg + lsdm_pkg::QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - lsdm_pkg::QCNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    assign pop_op       = slot_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == lsdm_pkg::QCNT_W'(lsdm_pkg::QUEUE_DEPTH));

endmodule

// ===== design/lsdm_engine.sv =====
// ----------------------------------------------------------------------------
// lsdm_engine
// Back side: owns the sample memory and the voice state, carries out one
// queued operation at a time. A tick walks the voices, reads two samples
// per active voice, interpolates, advances the phase, then scales the sum
// by the gain in two partial products and saturates into the output register.
// ----------------------------------------------------------------------------
module lsdm_engine #(
    parameter int VOICE_COUNT = 4,
    parameter int LOOP_DEPTH  = 4096
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 op_valid,
    input  lsdm_pkg::op_t                        op,
    output logic                                 op_pop,
    input  logic [lsdm_pkg::GAIN_W-1:0]          master_gain,
    input  logic [lsdm_pkg::PITCH_W-1:0]         pitch_factor,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [lsdm_pkg::OUT_W-1:0]    m_mixed_sample
);

    localparam int FW        = lsdm_pkg::FRAC_W;
    localparam int IDX_W     = $clog2(LOOP_DEPTH);
    localparam int LEN_W     = $clog2(LOOP_DEPTH + 1);
    localparam int PH_W      = LEN_W + FW;
    localparam int MEM_DEPTH = VOICE_COUNT * LOOP_DEPTH;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int VI_W      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int MULT_W    = lsdm_pkg::RATE_W + lsdm_pkg::PITCH_W;
    localparam int STEP_W    = MULT_W - FW;
    localparam int CMP_W     = (STEP_W > PH_W) ? STEP_W : PH_W;
    localparam int VAL_W     = lsdm_pkg::SAMPLE_W + FW + 2;
    localparam int ACC_W     = VAL_W + 1 + VI_W;
    localparam int PLO_W     = FW + lsdm_pkg::GAIN_W + 1;
    localparam int PHI_W     = ACC_W - FW + lsdm_pkg::GAIN_W + 1;
    localparam int PROD_W    = PHI_W + FW + 1;
    localparam int RND_SHIFT = 30;

    localparam logic [PLO_W-1:0]         ROUND_HALF = PLO_W'(1) << (RND_SHIFT - 1);
    localparam logic signed [PROD_W-1:0] SAT_HI     = PROD_W'(lsdm_pkg::OUT_MAX);
    localparam logic signed [PROD_W-1:0] SAT_LO     = PROD_W'(lsdm_pkg::OUT_MIN);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_SCAN    = 8'b0000_0010,
        ST_READ1   = 8'b0000_0100,
        ST_MUL0    = 8'b0000_1000,
        ST_MUL1    = 8'b0001_0000,
        ST_GAIN_LO = 8'b0010_0000,
        ST_GAIN_HI = 8'b0100_0000,
        ST_EMIT    = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // voice state
    logic [LEN_W-1:0]                    len_reg   [VOICE_COUNT];
    logic [lsdm_pkg::RATE_W-1:0]         rate_reg  [VOICE_COUNT];
    logic [PH_W-1:0]                     phase_reg [VOICE_COUNT];
    logic [VOICE_COUNT-1:0]              on_reg;
    logic [VI_W-1:0]                     vcnt_reg;

    // sample memory
    logic signed [lsdm_pkg::SAMPLE_W-1:0] mem [MEM_DEPTH];
    logic signed [lsdm_pkg::SAMPLE_W-1:0] rd_reg;
    logic [MEM_AW-1:0]                    raddr;
    logic [MEM_AW-1:0]                    waddr;
    logic                                 mem_we;

    // per-voice working registers
    logic [IDX_W-1:0]                idx1_reg;
    logic [FW-1:0]                   frac_reg;
    logic [STEP_W-1:0]               step_reg;
    logic [PH_W-1:0]                 stepc_reg;
    logic [PH_W:0]                   psum_reg;
    logic signed [VAL_W-1:0]         prod0_reg;
    logic signed [VAL_W-1:0]         prod1_reg;
    logic signed [ACC_W-1:0]         acc_reg;
    logic [PLO_W-1:0]                plo_reg;
    logic signed [PHI_W-1:0]         phi_reg;

    // output register
    logic                            m_valid_reg;
    logic signed [lsdm_pkg::OUT_W-1:0] m_mixed_sample_reg;

    // combinational helpers
    logic [LEN_W-1:0]                cur_len;
    logic [lsdm_pkg::RATE_W-1:0]     cur_rate;
    logic [PH_W-1:0]                 cur_phase;
    logic                            cur_active;
    logic                            last_voice;
    logic [LEN_W-1:0]                ph_idx;
    logic [LEN_W-1:0]                idx0_l;
    logic [LEN_W-1:0]                idx1_l;
    logic [LEN_W-1:0]                idx1_w;
    logic [MEM_AW-1:0]               voice_base;
    logic [MULT_W-1:0]               step_full;
    logic [PH_W-1:0]                 span_m1;
    logic [PH_W-1:0]                 step_clamped;
    logic [PH_W:0]                   span_ext;
    logic [PH_W-1:0]                 phase_wrapped;
    logic [FW:0]                     wt0;
    logic signed [PROD_W-1:0]        scaled_full;
    logic signed [PROD_W-1:0]        scaled_shr;
    logic signed [lsdm_pkg::OUT_W-1:0] sat_value;
    logic                            out_free;
    logic                            cmd_take;

    // current voice view
    assign cur_len    = len_reg[vcnt_reg];
    assign cur_rate   = rate_reg[vcnt_reg];
    assign cur_phase  = phase_reg[vcnt_reg];
    assign cur_active = on_reg[vcnt_reg] && (cur_len != '0);
    assign last_voice = (vcnt_reg == VI_W'(VOICE_COUNT - 1));

    // neighbouring sample positions with wrap at the loop length
    assign ph_idx = cur_phase[PH_W-1:FW];
    assign idx0_l = (ph_idx >= cur_len) ? '0 : ph_idx;
    assign idx1_l = idx0_l + LEN_W'(1);
    assign idx1_w = (idx1_l >= cur_len) ? '0 : idx1_l;

    // memory addressing
    assign voice_base = MEM_AW'(vcnt_reg) * MEM_AW'(LOOP_DEPTH);
    assign raddr = (state_reg == ST_SCAN) ?
                   voice_base + MEM_AW'(IDX_W'(idx0_l)) :
                   voice_base + MEM_AW'(idx1_reg);
    assign waddr = MEM_AW'(op.voice) * MEM_AW'(LOOP_DEPTH) + MEM_AW'(op.address);

    // phase step: rate times pitch, clamped below the loop span
    assign step_full    = MULT_W'(cur_rate) * MULT_W'(pitch_factor);
    assign span_m1      = {cur_len, {FW{1'b0}}} - PH_W'(1);
    assign step_clamped = (CMP_W'(step_reg) > CMP_W'(span_m1)) ?
                          span_m1 : PH_W'(step_reg);
    assign span_ext      = {1'b0, cur_len, {FW{1'b0}}};
    assign phase_wrapped = (psum_reg >= span_ext) ?
                           PH_W'(psum_reg - span_ext) : PH_W'(psum_reg);

    // weight of the first sample
    assign wt0 = {1'b1, {FW{1'b0}}} - {1'b0, frac_reg};

    // final scaling, rounding already folded into the low partial product
    assign scaled_full = (PROD_W'(phi_reg) <<< FW) + PROD_W'($signed({1'b0, plo_reg}));
    assign scaled_shr  = scaled_full >>> RND_SHIFT;
    assign sat_value   = (scaled_shr > SAT_HI) ? lsdm_pkg::OUT_W'(SAT_HI) :
                         (scaled_shr < SAT_LO) ? lsdm_pkg::OUT_W'(SAT_LO) :
                         lsdm_pkg::OUT_W'(scaled_shr);

    assign out_free = !m_valid_reg || m_ready;
    assign cmd_take = (state_reg == ST_IDLE) && op_valid;
    assign op_pop   = cmd_take;
    assign mem_we   = cmd_take && (op.kind == lsdm_pkg::CMD_LOAD);

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (op_valid && op.kind == lsdm_pkg::CMD_TICK) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cur_active) begin
                    state_next = ST_READ1;
                end else if (last_voice) begin
                    state_next = ST_GAIN_LO;
                end
            end
            ST_READ1:   state_next = ST_MUL0;
            ST_MUL0:    state_next = ST_MUL1;
            ST_MUL1:    state_next = last_voice ? ST_GAIN_LO : ST_SCAN;
            ST_GAIN_LO: state_next = ST_GAIN_HI;
            ST_GAIN_HI: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // control state, voice state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            vcnt_reg    <= '0;
            on_reg      <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < VOICE_COUNT; i++) begin
                len_reg[i]   <= '0;
                rate_reg[i]  <= '0;
                phase_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;

            // commands
            if (cmd_take) begin
                case (op.kind)
                    lsdm_pkg::CMD_SET_VOICE: begin
                        for (int i = 0; i < VOICE_COUNT; i++) begin
                            if (int'(op.voice) == i) begin
                                len_reg[i]   <= LEN_W'(op.length);
                                rate_reg[i]  <= op.rate;
                                phase_reg[i] <= '0;
                                on_reg[i]    <= 1'b0;
                            end
                        end
                    end
                    lsdm_pkg::CMD_TOGGLE: begin
                        for (int i = 0; i < VOICE_COUNT; i++) begin
                            if (int'(op.voice) == i) begin
                                on_reg[i] <= !on_reg[i];
                                if (!on_reg[i]) begin
                                    phase_reg[i] <= '0;
                                end
                            end
                        end
                    end
                    lsdm_pkg::CMD_ALL_OFF: begin
                        on_reg <= '0;
                    end
                    lsdm_pkg::CMD_TICK: begin
                        vcnt_reg <= '0;
                    end
                    default: begin
                    end
                endcase
            end

            // walk to the next voice
            if ((state_reg == ST_SCAN && !cur_active && !last_voice) ||
                (state_reg == ST_MUL1 && !last_voice)) begin
                vcnt_reg <= vcnt_reg + VI_W'(1);
            end

            // phase advance with a single wrap
            if (state_reg == ST_MUL1) begin
                for (int i = 0; i < VOICE_COUNT; i++) begin
                    if (int'(vcnt_reg) == i) begin
                        phase_reg[i] <= phase_wrapped;
                    end
                end
            end

            // output handshake
            if (state_reg == ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // sample memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[waddr] <= op.sample;
        end
        rd_reg <= mem[raddr];
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                acc_reg <= '0;
            end
            ST_SCAN: begin
                idx1_reg <= IDX_W'(idx1_w);
                frac_reg <= cur_phase[FW-1:0];
                step_reg <= step_full[MULT_W-1:FW];
            end
            ST_READ1: begin
                prod0_reg <= rd_reg * $signed({1'b0, wt0});
                stepc_reg <= step_clamped;
            end
            ST_MUL0: begin
                prod1_reg <= rd_reg * $signed({2'b00, frac_reg});
                psum_reg  <= {1'b0, cur_phase} + {1'b0, stepc_reg};
            end
            ST_MUL1: begin
                acc_reg <= acc_reg + ACC_W'(prod0_reg) + ACC_W'(prod1_reg);
            end
            ST_GAIN_LO: begin
                plo_reg <= PLO_W'(acc_reg[FW-1:0]) * PLO_W'(master_gain) + ROUND_HALF;
            end
            ST_GAIN_HI: begin
                // upper part of the sum keeps its sign
                phi_reg <= $signed(acc_reg[ACC_W-1:FW]) * $signed({1'b0, master_gain});
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_mixed_sample_reg <= sat_value;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_mixed_sample = m_mixed_sample_reg;

endmodule

// ===== design/looping_sample_drone_mixer.sv =====
// ----------------------------------------------------------------------------
// looping_sample_drone_mixer
// Plays up to VOICE_COUNT looping sample voices with linear interpolation
// and mixes them into one gained, saturated sample on every tick command.
//
//   port group   direction  handshake           carries
//   s_*          in         s_valid / s_ready   one command item
//   m_*          out        m_valid / m_ready   one mixed sample item per tick
//   cfg_*        in         cfg_write           master gain, pitch factor
//
// Load, set voice, toggle and all-off are carried out while the back end stays idle.
// A tick walks every voice: each active voice needs two reads through the
// single read port of the sample memory and two interpolation multiplies,
// and the gain takes two more products.
// A two-entry queue lets the input side keep taking items while the back
// end works or the output register waits on m_ready.
// Reset clears voices and configuration; the sample memory is not cleared.
// ----------------------------------------------------------------------------
module looping_sample_drone_mixer #(
    parameter int VOICE_COUNT = 4,
    parameter int LOOP_DEPTH  = 4096
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [lsdm_pkg::CMD_W-1:0]            s_command,
    input  logic [lsdm_pkg::VOICE_W-1:0]          s_voice,
    input  logic [lsdm_pkg::ADDR_W-1:0]           s_address,
    input  logic signed [lsdm_pkg::SAMPLE_W-1:0]  s_sample_value,
    input  logic [lsdm_pkg::LENGTH_W-1:0]         s_length,
    input  logic [lsdm_pkg::RATE_W-1:0]           s_rate,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [lsdm_pkg::OUT_W-1:0]     m_mixed_sample,
    input  logic                                  cfg_write,
    input  logic [lsdm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lsdm_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    logic [lsdm_pkg::GAIN_W-1:0]   gain_reg;
    logic [lsdm_pkg::PITCH_W-1:0]  pitch_reg;

    lsdm_pkg::queue_status_t  q_status;
    lsdm_pkg::op_t            q_push_op;
    lsdm_pkg::op_t            q_pop_op;
    logic                     q_push;
    logic                     q_pop;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg  <= lsdm_pkg::GAIN_RESET;
            pitch_reg <= lsdm_pkg::PITCH_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                lsdm_pkg::CFG_MASTER_GAIN:  gain_reg  <= cfg_wdata[lsdm_pkg::GAIN_W-1:0];
                lsdm_pkg::CFG_PITCH_FACTOR: pitch_reg <= cfg_wdata[lsdm_pkg::PITCH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input decode
    lsdm_front #(
        .VOICE_COUNT (VOICE_COUNT),
        .LOOP_DEPTH  (LOOP_DEPTH)
    ) u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_voice        (s_voice),
        .s_address      (s_address),
        .s_sample_value (s_sample_value),
        .s_length       (s_length),
        .s_rate         (s_rate),
        .q_status       (q_status),
        .q_push         (q_push),
        .q_op           (q_push_op)
    );

    // command queue
    lsdm_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_op (q_push_op),
        .pop     (q_pop),
        .pop_op  (q_pop_op),
        .status  (q_status)
    );

    // execution and mixing
    lsdm_engine #(
        .VOICE_COUNT (VOICE_COUNT),
        .LOOP_DEPTH  (LOOP_DEPTH)
    ) u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .op_valid       (!q_status.empty),
        .op             (q_pop_op),
        .op_pop         (q_pop),
        .master_gain    (gain_reg),
        .pitch_factor   (pitch_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mixed_sample (m_mixed_sample)
    );

    // back end never takes from an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_status.empty)
        else $error("operation taken from empty queue");

    // front end never pushes into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_status.full)
        else $error("operation pushed into full queue");

    // a push into an empty queue is visible on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && !q_pop && q_status.empty) |=> !q_status.empty)
        else $error("queued operation lost");

    // no result straight out of reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the looping sample drone mixer. Command items are
// sent in random bursts and the mixed samples are taken with random stalls.
// A scoreboard object keeps its own copy of the voices, sample words and
// registers. It works out each tick's mixed sample and compares it with the
// output in order. A short directed part covers the corner cases. Random
// traffic follows under several gain and pitch settings, extremes included.
// Sample words are loaded before any tick that would read them.
// ----------------------------------------------------------------------------

localparam int MIX_VOICES = 4;
localparam int MIX_DEPTH  = 4096;
localparam int PHASE_W    = 28;
// Q.16 voice values times Q2.14 gain
localparam int MIX_SHIFT  = lsdm_pkg::FRAC_W + 14;

typedef struct {
    logic [lsdm_pkg::CMD_W-1:0]           command;
    logic [lsdm_pkg::VOICE_W-1:0]         voice;
    logic [lsdm_pkg::ADDR_W-1:0]          address;
    logic signed [lsdm_pkg::SAMPLE_W-1:0] sample;
    logic [lsdm_pkg::LENGTH_W-1:0]        length;
    logic [lsdm_pkg::RATE_W-1:0]          rate;
} drone_cmd_t;

class drone_mix_checker;
    logic signed [lsdm_pkg::SAMPLE_W-1:0] sample_mem [MIX_VOICES*MIX_DEPTH];
    bit                                   loaded     [MIX_VOICES*MIX_DEPTH];
    logic [lsdm_pkg::LENGTH_W-1:0]        loop_len   [MIX_VOICES];
    logic [lsdm_pkg::RATE_W-1:0]          base_rate  [MIX_VOICES];
    logic [PHASE_W-1:0]                   phase      [MIX_VOICES];
    bit                                   playing    [MIX_VOICES];
    logic [lsdm_pkg::GAIN_W-1:0]          gain;
    logic [lsdm_pkg::PITCH_W-1:0]         pitch;
    logic signed [lsdm_pkg::OUT_W-1:0]    expected_mix [$];
    int                                   mismatch_count;
    int                                   checked_count;

    function new();
        gain = lsdm_pkg::GAIN_RESET;
        pitch = lsdm_pkg::PITCH_RESET;
        foreach (loop_len[v]) begin
            loop_len[v] = '0;
            base_rate[v] = '0;
            phase[v] = '0;
            playing[v] = 1'b0;
        end
        mismatch_count = 0;
        checked_count = 0;
    endfunction

    function void set_register(logic [lsdm_pkg::CFG_IDX_W-1:0] index,
                               logic [lsdm_pkg::CFG_DATA_W-1:0] data);
        case (index)
            lsdm_pkg::CFG_MASTER_GAIN:  gain = data[lsdm_pkg::GAIN_W-1:0];
            lsdm_pkg::CFG_PITCH_FACTOR: pitch = data[lsdm_pkg::PITCH_W-1:0];
            default: ;
        endcase
    endfunction

    // two neighbouring sample positions of a voice, wrapped at the loop length
    function void read_positions(int unsigned v, output int unsigned i0,
                                 output int unsigned i1);
        i0 = 32'(phase[v] >> lsdm_pkg::FRAC_W);
        if (i0 >= loop_len[v])
            i0 = 0;
        i1 = i0 + 1;
        if (i1 >= loop_len[v])
            i1 = 0;
    endfunction

    // first sample word the next tick would read before anything was loaded
    function bit find_unloaded(output int unsigned slot);
        int unsigned v, i0, i1;
        slot = 0;
        for (v = 0; v < MIX_VOICES; v++) begin
            if (playing[v] && loop_len[v] != 0) begin
                read_positions(v, i0, i1);
                if (!loaded[v*MIX_DEPTH + i0]) begin
                    slot = v*MIX_DEPTH + i0;
                    return 1'b1;
                end
                if (!loaded[v*MIX_DEPTH + i1]) begin
                    slot = v*MIX_DEPTH + i1;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // interpolate every sounding voice, advance the phases, gain and saturate
    function logic signed [lsdm_pkg::OUT_W-1:0] mix_tick();
        longint total, scaled, span, advance, frac, s0, s1;
        int unsigned v, i0, i1, base;
        total = 0;
        for (v = 0; v < MIX_VOICES; v++) begin
            if (playing[v] && loop_len[v] != 0) begin
                read_positions(v, i0, i1);
                base = v * MIX_DEPTH;
                frac = longint'(phase[v][lsdm_pkg::FRAC_W-1:0]);
                s0 = longint'(sample_mem[base + i0]);
                s1 = longint'(sample_mem[base + i1]);
                total += s0 * ((longint'(1) << lsdm_pkg::FRAC_W) - frac) + s1 * frac;
                // step held below the span, so one subtraction wraps
                span = longint'(loop_len[v]) << lsdm_pkg::FRAC_W;
                advance = (longint'(base_rate[v]) * longint'(pitch)) >> lsdm_pkg::FRAC_W;
                if (advance > span - 1)
                    advance = span - 1;
                advance += longint'(phase[v]);
                if (advance >= span)
                    advance -= span;
                phase[v] = advance[PHASE_W-1:0];
            end
        end
        // round half upward, then clamp to the output range
        scaled = (total * longint'(gain) + (longint'(1) << (MIX_SHIFT - 1))) >>> MIX_SHIFT;
        if (scaled > lsdm_pkg::OUT_MAX)
            scaled = lsdm_pkg::OUT_MAX;
        if (scaled < lsdm_pkg::OUT_MIN)
            scaled = lsdm_pkg::OUT_MIN;
        return scaled[lsdm_pkg::OUT_W-1:0];
    endfunction

    // accepted command item: update the voices, queue a sample for a tick
    function void note_command(drone_cmd_t c);
        int unsigned slot;
        case (c.command)
            lsdm_pkg::CMD_LOAD: begin
                slot = c.voice * MIX_DEPTH + c.address;
                sample_mem[slot] = c.sample;
                loaded[slot] = 1'b1;
            end
            lsdm_pkg::CMD_SET_VOICE: begin
                loop_len[c.voice] = (c.length > MIX_DEPTH) ?
                                    lsdm_pkg::LENGTH_W'(MIX_DEPTH) : c.length;
                base_rate[c.voice] = c.rate;
                phase[c.voice] = '0;
                playing[c.voice] = 1'b0;
            end
            lsdm_pkg::CMD_TOGGLE: begin
                playing[c.voice] = !playing[c.voice];
                if (playing[c.voice])
                    phase[c.voice] = '0;
            end
            lsdm_pkg::CMD_ALL_OFF: begin
                foreach (playing[v])
                    playing[v] = 1'b0;
            end
            lsdm_pkg::CMD_TICK: expected_mix.push_back(mix_tick());
            default: ;
        endcase
    endfunction

    function void check_mixed(logic signed [lsdm_pkg::OUT_W-1:0] got);
        logic signed [lsdm_pkg::OUT_W-1:0] want;
        if (expected_mix.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mixed sample %0d arrived with no tick waiting", got);
            return;
        end
        want = expected_mix.pop_front();
        checked_count++;
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mixed sample %0d: expected %0d, got %0d",
                         checked_count, want, got);
        end
    endfunction

    function int pending();
        return expected_mix.size();
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_ITEMS  = 250;
    localparam int QUIET_CYCLES = 48;
    localparam int RUN_LIMIT_NS = 10_000_000;
    localparam int NOISE_W      = lsdm_pkg::CFG_DATA_W - lsdm_pkg::GAIN_W;

    localparam logic [lsdm_pkg::CMD_W-1:0]           CMD_RESERVED_FIRST = 3'd5;
    localparam logic [lsdm_pkg::CMD_W-1:0]           CMD_RESERVED_LAST  = 3'd7;
    localparam logic signed [lsdm_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [lsdm_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic [lsdm_pkg::RATE_W-1:0]          RATE_MAX   = '1;
    localparam logic [lsdm_pkg::RATE_W-1:0]          RATE_HALF  = 20'h08000;
    localparam logic [lsdm_pkg::LENGTH_W-1:0]        LENGTH_MAX = '1;
    localparam logic [lsdm_pkg::GAIN_W-1:0]          GAIN_MAX   = '1;
    localparam logic [lsdm_pkg::PITCH_W-1:0]         PITCH_MAX  = '1;

    logic                                  aclk = 1'b0;
    logic                                  aresetn = 1'b0;
    logic                                  s_valid = 1'b0;
    logic                                  s_ready;
    logic [lsdm_pkg::CMD_W-1:0]            s_command = '0;
    logic [lsdm_pkg::VOICE_W-1:0]          s_voice = '0;
    logic [lsdm_pkg::ADDR_W-1:0]           s_address = '0;
    logic signed [lsdm_pkg::SAMPLE_W-1:0]  s_sample_value = '0;
    logic [lsdm_pkg::LENGTH_W-1:0]         s_length = '0;
    logic [lsdm_pkg::RATE_W-1:0]           s_rate = '0;
    logic                                  m_valid;
    logic                                  m_ready = 1'b0;
    logic signed [lsdm_pkg::OUT_W-1:0]     m_mixed_sample;
    logic                                  cfg_write = 1'b0;
    logic [lsdm_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
    logic [lsdm_pkg::CFG_DATA_W-1:0]       cfg_wdata = '0;

    drone_mix_checker mixer = new();

    int command_count = 0;
    int settings_count = 1;
    int burst_left = 0;
    int sink_mode = 0;
    int sink_hold = 0;

    looping_sample_drone_mixer #(
        .VOICE_COUNT(MIX_VOICES),
        .LOOP_DEPTH (MIX_DEPTH)
    ) dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver: free-flowing, random and mostly stalled stretches
    always @(posedge aclk) begin
        if (sink_hold == 0) begin
            sink_mode = $urandom_range(0, 2);
            sink_hold = $urandom_range(20, 300);
        end else begin
            sink_hold = sink_hold - 1;
        end
        case (sink_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            mixer.check_mixed(m_mixed_sample);
    end

    function automatic logic signed [lsdm_pkg::SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            default: return lsdm_pkg::SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // mostly short loops, now and then the full depth or an oversized length
    function automatic logic [lsdm_pkg::LENGTH_W-1:0] random_length();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return lsdm_pkg::LENGTH_W'(MIX_DEPTH);
            2: return lsdm_pkg::LENGTH_W'($urandom_range(MIX_DEPTH + 1, LENGTH_MAX));
            3: return lsdm_pkg::LENGTH_W'($urandom_range(65, MIX_DEPTH - 1));
            default: return lsdm_pkg::LENGTH_W'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic logic [lsdm_pkg::RATE_W-1:0] random_rate();
        case ($urandom_range(0, 7))
            0: return RATE_MAX;
            1, 2: return lsdm_pkg::RATE_W'($urandom_range(0, RATE_MAX));
            3, 4, 5: return lsdm_pkg::RATE_W'($urandom_range(0, 20'h1FFFF));
            default: return lsdm_pkg::RATE_W'($urandom_range(0, 20'h03FFF));
        endcase
    endfunction

    // fields random, command a tick by default; unused fields of a command carry noise
    function automatic drone_cmd_t random_fields();
        drone_cmd_t c;
        c.command = lsdm_pkg::CMD_TICK;
        c.voice = lsdm_pkg::VOICE_W'($urandom_range(0, MIX_VOICES - 1));
        c.address = lsdm_pkg::ADDR_W'($urandom_range(0, MIX_DEPTH - 1));
        c.sample = random_sample();
        c.length = random_length();
        c.rate = random_rate();
        return c;
    endfunction

    function automatic drone_cmd_t command_for(logic [lsdm_pkg::CMD_W-1:0] cmd,
                                               logic [lsdm_pkg::VOICE_W-1:0] voice);
        drone_cmd_t c;
        c = random_fields();
        c.command = cmd;
        c.voice = voice;
        return c;
    endfunction

    // one item over the input channel, with bursts and gaps
    task automatic send_item(drone_cmd_t c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_command <= c.command;
        s_voice <= c.voice;
        s_address <= c.address;
        s_sample_value <= c.sample;
        s_length <= c.length;
        s_rate <= c.rate;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        mixer.note_command(c);
        if (c.command <= lsdm_pkg::CMD_TICK)
            command_count++;
    endtask

    // load any sample word the tick would read, then tick
    task automatic send_tick(drone_cmd_t c);
        drone_cmd_t fill;
        int unsigned slot;
        while (mixer.find_unloaded(slot)) begin
            fill = command_for(lsdm_pkg::CMD_LOAD, lsdm_pkg::VOICE_W'(slot / MIX_DEPTH));
            fill.address = lsdm_pkg::ADDR_W'(slot % MIX_DEPTH);
            send_item(fill);
        end
        c.command = lsdm_pkg::CMD_TICK;
        send_item(c);
    endtask

    // well-formed phrase: set a voice, start it, let it play a few ticks
    task automatic send_voice_phrase(logic [lsdm_pkg::VOICE_W-1:0] voice);
        int ticks;
        send_item(command_for(lsdm_pkg::CMD_SET_VOICE, voice));
        send_item(command_for(lsdm_pkg::CMD_TOGGLE, voice));
        ticks = $urandom_range(2, 8);
        repeat (ticks) send_tick(random_fields());
    endtask

    task automatic send_random_command();
        drone_cmd_t c;
        int pick;
        c = random_fields();
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            send_voice_phrase(c.voice);
        end else if (pick < 45) begin
            send_tick(c);
        end else if (pick < 68) begin
            c.command = lsdm_pkg::CMD_LOAD;
            send_item(c);
        end else if (pick < 76) begin
            c.command = lsdm_pkg::CMD_SET_VOICE;
            send_item(c);
        end else if (pick < 90) begin
            c.command = lsdm_pkg::CMD_TOGGLE;
            send_item(c);
        end else if (pick < 95) begin
            c.command = lsdm_pkg::CMD_ALL_OFF;
            send_item(c);
        end else begin
            c.command = lsdm_pkg::CMD_W'($urandom_range(CMD_RESERVED_FIRST,
                                                         CMD_RESERVED_LAST));
            send_item(c);
        end
    endtask

    task automatic random_commands(int count);
        int goal;
        goal = command_count + count;
        while (command_count < goal)
            send_random_command();
    endtask

    // drop valid, let every tick drain and the back end settle
    task automatic wait_quiet();
        s_valid <= 1'b0;
        burst_left = 0;
        while (mixer.pending() != 0)
            @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(logic [lsdm_pkg::CFG_IDX_W-1:0] index,
                                  logic [lsdm_pkg::CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge aclk);
        mixer.set_register(index, data);
    endtask

    task automatic set_mix_registers(logic [lsdm_pkg::GAIN_W-1:0] gain,
                                     logic [lsdm_pkg::PITCH_W-1:0] pitch);
        logic [lsdm_pkg::CFG_DATA_W-1:0] gain_word;
        wait_quiet();
        // bits above the gain field are noise that must be dropped
        gain_word = lsdm_pkg::CFG_DATA_W'(gain);
        gain_word[lsdm_pkg::CFG_DATA_W-1:lsdm_pkg::GAIN_W] =
            NOISE_W'($urandom_range(0, 3));
        write_register(lsdm_pkg::CFG_MASTER_GAIN, gain_word);
        write_register(lsdm_pkg::CFG_PITCH_FACTOR, lsdm_pkg::CFG_DATA_W'(pitch));
        cfg_write <= 1'b0;
        settings_count++;
    endtask

    // run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("run stopped at the time limit, %0d mixed samples still due",
                 mixer.pending());
        $display("Mismatches found");
        $finish;
    end

    initial begin
        drone_cmd_t c;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: silent tick with nothing playing
        send_tick(random_fields());
        // two-sample loop at half rate between the sample extremes
        c = command_for(lsdm_pkg::CMD_LOAD, lsdm_pkg::VOICE_W'(0));
        c.address = '0;
        c.sample = SAMPLE_MAX;
        send_item(c);
        c.address = lsdm_pkg::ADDR_W'(1);
        c.sample = SAMPLE_MIN;
        send_item(c);
        c = command_for(lsdm_pkg::CMD_SET_VOICE, lsdm_pkg::VOICE_W'(0));
        c.length = lsdm_pkg::LENGTH_W'(2);
        c.rate = RATE_HALF;
        send_item(c);
        send_item(command_for(lsdm_pkg::CMD_TOGGLE, lsdm_pkg::VOICE_W'(0)));
        send_tick(random_fields());
        send_tick(random_fields());
        // oversized length saturates to the full depth, top address loaded
        c = command_for(lsdm_pkg::CMD_LOAD, lsdm_pkg::VOICE_W'(1));
        c.address = lsdm_pkg::ADDR_W'(MIX_DEPTH - 1);
        send_item(c);
        c = command_for(lsdm_pkg::CMD_SET_VOICE, lsdm_pkg::VOICE_W'(1));
        c.length = LENGTH_MAX;
        c.rate = RATE_MAX;
        send_item(c);
        send_item(command_for(lsdm_pkg::CMD_TOGGLE, lsdm_pkg::VOICE_W'(1)));
        send_tick(random_fields());
        // zero-length voice switched on stays silent
        c = command_for(lsdm_pkg::CMD_SET_VOICE, lsdm_pkg::VOICE_W'(2));
        c.length = '0;
        c.rate = RATE_MAX;
        send_item(c);
        send_item(command_for(lsdm_pkg::CMD_TOGGLE, lsdm_pkg::VOICE_W'(2)));
        // single-sample loop at full rate: step clamped below the span
        c = command_for(lsdm_pkg::CMD_SET_VOICE, lsdm_pkg::VOICE_W'(3));
        c.length = lsdm_pkg::LENGTH_W'(1);
        c.rate = RATE_MAX;
        send_item(c);
        send_item(command_for(lsdm_pkg::CMD_TOGGLE, lsdm_pkg::VOICE_W'(3)));
        send_tick(random_fields());
        send_tick(random_fields());
        // unknown commands change nothing
        send_item(command_for(CMD_RESERVED_FIRST, lsdm_pkg::VOICE_W'(0)));
        send_item(command_for(CMD_RESERVED_LAST, lsdm_pkg::VOICE_W'(3)));
        send_item(command_for(lsdm_pkg::CMD_TOGGLE, lsdm_pkg::VOICE_W'(0)));
        send_tick(random_fields());
        send_item(command_for(lsdm_pkg::CMD_ALL_OFF, lsdm_pkg::VOICE_W'(0)));
        send_tick(random_fields());

        // random traffic under several register settings
        random_commands(PHASE_ITEMS);
        set_mix_registers(GAIN_MAX, PITCH_MAX);
        random_commands(PHASE_ITEMS);
        set_mix_registers('0, '0);
        random_commands(100);
        set_mix_registers(lsdm_pkg::GAIN_W'($urandom_range(0, GAIN_MAX)),
                          lsdm_pkg::PITCH_W'($urandom_range(0, PITCH_MAX)));
        random_commands(PHASE_ITEMS);
        set_mix_registers(lsdm_pkg::GAIN_RESET, lsdm_pkg::PITCH_RESET);
        random_commands(PHASE_ITEMS);

        wait_quiet();
        if (mixer.pending() != 0) begin
            $display("%0d mixed samples never arrived", mixer.pending());
            mixer.mismatch_count += mixer.pending();
        end
        $display("covered %0d command items under %0d register settings",
                 command_count, settings_count);
        $display("%0d mixed samples compared, %0d failures",
                 mixer.checked_count, mixer.mismatch_count);
        if (mixer.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== looping_sample_drone_mixer.f =====
design/lsdm_pkg.sv
design/lsdm_front.sv
design/lsdm_queue.sv
design/lsdm_engine.sv
design/looping_sample_drone_mixer.sv
dv/tb.sv
